### rtl/core/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared types and fixed-point constants for the normal CDF pipeline.
// ----------------------------------------------------------------------------
package ncdf_pkg;

   typedef struct packed {
      logic signed [31:0] sample;
      logic signed [31:0] mean;
      logic [30:0]        std_dev;
   } req_type;

   typedef struct packed {
      logic [16:0] probability;
      logic        bad_deviation;
   } rsp_type;

   // |z| in Q4.28, t in Q30, density in Q30
   localparam int AZ_W   = 32;
   localparam int T_W    = 31;
   localparam int DENS_W = 29;

   localparam logic [AZ_W-1:0] AZ_CLAMP    = 32'h8000_0000;   // 8.0 in Q28
   localparam logic [29:0]     K_T         = 30'd994894385;   // 0.2316419, Q32
   localparam logic [28:0]     INV_SQRT2PI = 29'd428361012;   // 1/sqrt(2 pi), Q30
   localparam logic [29:0]     LN2_Q       = 30'd744261118;   // ln 2, Q30
   localparam logic [29:0]     ONE_Q28     = 30'd268435456;
   localparam logic [29:0]     RECIP_SEED  = 30'd134217728;   // 2^58 >> 31
   localparam logic [16:0]     OUT_ONE     = 17'd65536;

   // polynomial coefficients b1..b5, Q30
   localparam logic signed [33:0] COEF_B [0:4] = '{
      34'sd342933307,
      -34'sd382857446,
      34'sd1912847369,
      -34'sd1955558716,
      34'sd1428371292
   };

   // floor(2^32 / k) for the series divisions by k
   localparam logic [32:0] RECIP_M [1:12] = '{
      33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
      33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
      33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
   };

endpackage

### rtl/core/normal_cdf_polynomial.sv
// ----------------------------------------------------------------------------
// normal_cdf_polynomial
// Normal cumulative probability by the five-term polynomial approximation.
// ----------------------------------------------------------------------------
// Fully pipelined: a transaction is taken on every cycle that start is high,
// busy is always low, and each transaction gives exactly one result, marked
// by a one-cycle rsp_strobe, in the order taken. There is no back-pressure;
// the receiver must take every strobe. Most of the stages lie in the two
// bit-per-stage dividers (|z| and t, 31 stages each) and the 12-term
// exponential series (three stages per term). Inputs are Q16.16 sample, mean
// and deviation; the result is Q1.16 (65536 = 1.0). A zero deviation sets
// bad_deviation and forces probability to 0.
// ----------------------------------------------------------------------------
module normal_cdf_polynomial (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ncdf_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ncdf_pkg::rsp_type rsp_data
);
   import ncdf_pkg::*;

   localparam int RC_TAG_W = AZ_W + 2;
   localparam int EX_TAG_W = T_W + 2;

   logic                zd_valid;
   logic [AZ_W-1:0]     zd_az;
   logic                zd_neg;
   logic                zd_bad;

   logic                rc_valid;
   logic [T_W-1:0]      rc_t;
   logic [RC_TAG_W-1:0] rc_tag;

   logic                ex_valid;
   logic [DENS_W-1:0]   ex_dens;
   logic [EX_TAG_W-1:0] ex_tag;

   // never stalls
   assign busy = 1'b0;

   // |z| = |x - m| / sd, Q4.28, clamped to 8
   ncdf_zdiv u_zdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_req    (req_data),
      .out_valid (zd_valid),
      .out_az    (zd_az),
      .out_neg   (zd_neg),
      .out_bad   (zd_bad)
   );

   // t = 1 / (1 + 0.2316419 |z|); |z| and flags ride along
   ncdf_recip #(.TAG_W(RC_TAG_W)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (zd_valid),
      .in_az     (zd_az),
      .in_tag    ({zd_az, zd_neg, zd_bad}),
      .out_valid (rc_valid),
      .out_t     (rc_t),
      .out_tag   (rc_tag)
   );

   // density from |z|; t and flags ride along
   ncdf_exp #(.TAG_W(EX_TAG_W)) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rc_valid),
      .in_az     (rc_tag[RC_TAG_W-1:2]),
      .in_tag    ({rc_t, rc_tag[1:0]}),
      .out_valid (ex_valid),
      .out_dens  (ex_dens),
      .out_tag   (ex_tag)
   );

   // polynomial, tail probability and output register
   ncdf_poly u_poly (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ex_valid),
      .in_t       (ex_tag[EX_TAG_W-1:2]),
      .in_dens    (ex_dens),
      .in_neg     (ex_tag[1]),
      .in_bad     (ex_tag[0]),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_data)
   );

endmodule

### rtl/core/ncdf_zdiv.sv
// ----------------------------------------------------------------------------
// ncdf_zdiv
// Difference, magnitude and pipelined restoring divide for |z| = |x-m|/sd.
// ----------------------------------------------------------------------------
module ncdf_zdiv (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ncdf_pkg::req_type         in_req,
   output logic                      out_valid,
   output logic [ncdf_pkg::AZ_W-1:0] out_az,
   output logic                      out_neg,
   output logic                      out_bad
);
   import ncdf_pkg::*;

   localparam int STEPS = 31;

   typedef struct packed {
      logic [33:0] rem;
      logic [33:0] d8;
      logic [30:0] quo;
      logic        sat;
      logic        neg;
      logic        bad;
   } zd_stage_type;

   logic               vld0_ff;
   logic signed [32:0] diff_ff;
   logic signed [32:0] diff_in;
   logic [30:0]        sd_ff;
   logic [32:0]        mag_in;
   zd_stage_type       first_in;
   zd_stage_type       st_ff  [0:STEPS];
   logic               vld_ff [0:STEPS];

   assign diff_in = {in_req.sample[31], in_req.sample} - {in_req.mean[31], in_req.mean};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= in_valid;
      end
      diff_ff <= diff_in;
      sd_ff   <= in_req.std_dev;
   end

   always_comb begin
      mag_in         = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
      first_in.rem   = {1'b0, mag_in};
      first_in.d8    = {sd_ff, 3'b000};
      first_in.quo   = '0;
      first_in.sat   = ({1'b0, mag_in} >= {sd_ff, 3'b000});
      first_in.neg   = diff_ff[32];
      first_in.bad   = (sd_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld0_ff;
      end
      st_ff[0] <= first_in;
   end

   // one quotient bit of |d| / (8 sd) per stage
   for (genvar s = 0; s < STEPS; s++) begin : g_div
      logic [34:0]  rem2;
      logic         ge;
      zd_stage_type nxt_in;

      always_comb begin
         rem2       = {st_ff[s].rem, 1'b0};
         ge         = (rem2 >= {1'b0, st_ff[s].d8});
         nxt_in     = st_ff[s];
         nxt_in.rem = ge ? 34'(rem2 - {1'b0, st_ff[s].d8}) : rem2[33:0];
         nxt_in.quo = {st_ff[s].quo[29:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         st_ff[s+1] <= nxt_in;
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_az    = st_ff[STEPS].sat ? AZ_CLAMP : {1'b0, st_ff[STEPS].quo};
   assign out_neg   = st_ff[STEPS].neg;
   assign out_bad   = st_ff[STEPS].bad;

endmodule

### rtl/core/ncdf_recip.sv
// ----------------------------------------------------------------------------
// ncdf_recip
// t = round(1 / (1 + 0.2316419 |z|)) in Q30, multiply then pipelined divide.
// ----------------------------------------------------------------------------
module ncdf_recip #(
   parameter int TAG_W = 34
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [ncdf_pkg::AZ_W-1:0] in_az,
   input  logic [TAG_W-1:0]          in_tag,
   output logic                      out_valid,
   output logic [ncdf_pkg::T_W-1:0]  out_t,
   output logic [TAG_W-1:0]          out_tag
);
   import ncdf_pkg::*;

   localparam int STEPS = 31;

   typedef struct packed {
      logic [29:0]      rem;
      logic [29:0]      denom;
      logic [T_W-1:0]   quo;
      logic [TAG_W-1:0] tag;
   } rc_stage_type;

   logic             vp_ff;
   logic [61:0]      prod_ff;
   logic [TAG_W-1:0] tag_ff;
   rc_stage_type     first_in;
   rc_stage_type     st_ff  [0:STEPS];
   logic             vld_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= in_valid;
      end
      prod_ff <= 62'(in_az) * 62'(K_T);
      tag_ff  <= in_tag;
   end

   always_comb begin
      first_in.denom = ONE_Q28 + prod_ff[61:32];
      first_in.rem   = RECIP_SEED;
      first_in.quo   = '0;
      first_in.tag   = tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vp_ff;
      end
      st_ff[0] <= first_in;
   end

   // dividend is 2^58 + denom/2: its low 31 bits are brought down one a stage
   for (genvar s = 0; s < STEPS; s++) begin : g_div
      localparam int BIT = STEPS - 1 - s;
      logic [30:0]  low;
      logic [30:0]  rem2;
      logic         ge;
      rc_stage_type nxt_in;

      always_comb begin
         low        = {2'b00, st_ff[s].denom[29:1]};
         rem2       = {st_ff[s].rem, low[BIT]};
         ge         = (rem2 >= {1'b0, st_ff[s].denom});
         nxt_in     = st_ff[s];
         nxt_in.rem = ge ? 30'(rem2 - {1'b0, st_ff[s].denom}) : rem2[29:0];
         nxt_in.quo = {st_ff[s].quo[T_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         st_ff[s+1] <= nxt_in;
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_t     = st_ff[STEPS].quo;
   assign out_tag   = st_ff[STEPS].tag;

endmodule

### rtl/core/ncdf_exp.sv
// ----------------------------------------------------------------------------
// ncdf_exp
// Density exp(-z^2/2)/sqrt(2 pi): range reduction by ln 2, 12-term series.
// ----------------------------------------------------------------------------
module ncdf_exp #(
   parameter int TAG_W = 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ncdf_pkg::AZ_W-1:0]   in_az,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [ncdf_pkg::DENS_W-1:0] out_dens,
   output logic [TAG_W-1:0]            out_tag
);
   import ncdf_pkg::*;

   localparam int RED_STEPS = 6;
   localparam int TERMS     = 12;
   localparam int SER_LAST  = 3 * TERMS + 3;

   typedef struct packed {
      logic [35:0]      rem;
      logic [5:0]       n;
      logic [TAG_W-1:0] tag;
   } rd_stage_type;

   typedef struct packed {
      logic [30:0]        term;
      logic signed [33:0] sum;
      logic [29:0]        r;
      logic [5:0]         n;
      logic [62:0]        prod;
      logic [29:0]        v;
      logic [TAG_W-1:0]   tag;
   } sr_stage_type;

   logic             vs_ff;
   logic [63:0]      sq_ff;
   logic [TAG_W-1:0] tag_ff;
   rd_stage_type     rd_ff  [0:RED_STEPS];
   logic             rdv_ff [0:RED_STEPS];
   sr_stage_type     sr_ff  [0:SER_LAST];
   logic             srv_ff [0:SER_LAST];
   sr_stage_type     seed_in;
   sr_stage_type     f1_in;
   sr_stage_type     f2_in;
   sr_stage_type     f3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else begin
         vs_ff <= in_valid;
      end
      sq_ff  <= 64'(in_az) * 64'(in_az);
      tag_ff <= in_tag;
   end

   // w = z^2/2 in Q30
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff[0] <= 1'b0;
      end else begin
         rdv_ff[0] <= vs_ff;
      end
      rd_ff[0].rem <= sq_ff[62:27];
      rd_ff[0].n   <= '0;
      rd_ff[0].tag <= tag_ff;
   end

   // n = floor(w / ln2), one bit a stage
   for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
      localparam int SH = RED_STEPS - 1 - j;
      logic [35:0]  cmp;
      logic         ge;
      rd_stage_type nxt_in;

      always_comb begin
         cmp        = 36'(LN2_Q) << SH;
         ge         = (rd_ff[j].rem >= cmp);
         nxt_in     = rd_ff[j];
         nxt_in.rem = ge ? rd_ff[j].rem - cmp : rd_ff[j].rem;
         nxt_in.n   = {rd_ff[j].n[4:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rdv_ff[j+1] <= 1'b0;
         end else begin
            rdv_ff[j+1] <= rdv_ff[j];
         end
         rd_ff[j+1] <= nxt_in;
      end
   end

   always_comb begin
      seed_in      = '0;
      seed_in.term = 31'h4000_0000;
      seed_in.sum  = 34'sh0_4000_0000;
      seed_in.r    = rd_ff[RED_STEPS].rem[29:0];
      seed_in.n    = rd_ff[RED_STEPS].n;
      seed_in.tag  = rd_ff[RED_STEPS].tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srv_ff[0] <= 1'b0;
      end else begin
         srv_ff[0] <= rdv_ff[RED_STEPS];
      end
      sr_ff[0] <= seed_in;
   end

   // term_k = ((term_{k-1} * r) >> 30) / k, summed with alternating sign
   for (genvar k = 1; k <= TERMS; k++) begin : g_term
      localparam int  B       = 3 * (k - 1);
      localparam bit  SUB_OLD = (k % 2 == 0);
      sr_stage_type a_in;
      sr_stage_type b_in;
      sr_stage_type c_in;
      logic [29:0]  q_est;
      logic [33:0]  rem_k;

      always_comb begin
         a_in      = sr_ff[B];
         a_in.prod = 63'(sr_ff[B].term) * 63'(sr_ff[B].r);
         if (k > 1) begin
            if (SUB_OLD) begin
               a_in.sum = sr_ff[B].sum - $signed({3'b000, sr_ff[B].term});
            end else begin
               a_in.sum = sr_ff[B].sum + $signed({3'b000, sr_ff[B].term});
            end
         end
      end

      always_comb begin
         b_in      = sr_ff[B+1];
         b_in.v    = sr_ff[B+1].prod[59:30];
         b_in.prod = 63'(sr_ff[B+1].prod[59:30]) * 63'(RECIP_M[k]);
      end

      always_comb begin
         q_est     = sr_ff[B+2].prod[61:32];
         rem_k     = 34'(sr_ff[B+2].v) - 34'(q_est) * 34'(k);
         c_in      = sr_ff[B+2];
         c_in.term = (rem_k >= 34'(k)) ? 31'(q_est) + 31'd1 : 31'(q_est);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            srv_ff[B+1] <= 1'b0;
            srv_ff[B+2] <= 1'b0;
            srv_ff[B+3] <= 1'b0;
         end else begin
            srv_ff[B+1] <= srv_ff[B];
            srv_ff[B+2] <= srv_ff[B+1];
            srv_ff[B+3] <= srv_ff[B+2];
         end
         sr_ff[B+1] <= a_in;
         sr_ff[B+2] <= b_in;
         sr_ff[B+3] <= c_in;
      end
   end

   // last term is even: add it, then clamp, scale by 2^-n, and weight
   always_comb begin
      f1_in     = sr_ff[3*TERMS];
      f1_in.sum = sr_ff[3*TERMS].sum + $signed({3'b000, sr_ff[3*TERMS].term});

      f2_in = sr_ff[3*TERMS+1];
      if (sr_ff[3*TERMS+1].sum[33] || (sr_ff[3*TERMS+1].n == 6'd63)) begin
         f2_in.term = '0;
      end else begin
         f2_in.term = 31'(sr_ff[3*TERMS+1].sum[32:0] >> sr_ff[3*TERMS+1].n);
      end

      f3_in      = sr_ff[3*TERMS+2];
      f3_in.prod = 63'(sr_ff[3*TERMS+2].term) * 63'(INV_SQRT2PI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srv_ff[3*TERMS+1] <= 1'b0;
         srv_ff[3*TERMS+2] <= 1'b0;
         srv_ff[3*TERMS+3] <= 1'b0;
      end else begin
         srv_ff[3*TERMS+1] <= srv_ff[3*TERMS];
         srv_ff[3*TERMS+2] <= srv_ff[3*TERMS+1];
         srv_ff[3*TERMS+3] <= srv_ff[3*TERMS+2];
      end
      sr_ff[3*TERMS+1] <= f1_in;
      sr_ff[3*TERMS+2] <= f2_in;
      sr_ff[3*TERMS+3] <= f3_in;
   end

   assign out_valid = srv_ff[SER_LAST];
   assign out_dens  = sr_ff[SER_LAST].prod[58:30];
   assign out_tag   = sr_ff[SER_LAST].tag;

endmodule

### rtl/core/ncdf_poly.sv
// ----------------------------------------------------------------------------
// ncdf_poly
// Horner polynomial in t, product with density and t, rounding, tail select.
// ----------------------------------------------------------------------------
module ncdf_poly (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [ncdf_pkg::T_W-1:0]    in_t,
   input  logic [ncdf_pkg::DENS_W-1:0] in_dens,
   input  logic                        in_neg,
   input  logic                        in_bad,
   output logic                        out_strobe,
   output ncdf_pkg::rsp_type           out_rsp
);
   import ncdf_pkg::*;

   localparam int HORNER = 4;
   localparam int LAST   = 2 * HORNER + 3;

   typedef struct packed {
      logic [T_W-1:0]     t;
      logic [DENS_W-1:0]  dens;
      logic signed [33:0] acc;
      logic [63:0]        prod;
      logic               msign;
      logic [32:0]        pos;
      logic [29:0]        dt;
      logic [16:0]        p16;
      logic               neg;
      logic               bad;
   } pl_stage_type;

   pl_stage_type st_ff  [0:LAST];
   logic         vld_ff [0:LAST];
   pl_stage_type first_in;
   pl_stage_type f1_in;
   pl_stage_type f2_in;
   pl_stage_type f3_in;
   rsp_type      rsp_in;
   rsp_type      rsp_ff;
   logic         strobe_ff;
   logic [16:0]  p_sat;

   always_comb begin
      first_in      = '0;
      first_in.t    = in_t;
      first_in.dens = in_dens;
      first_in.acc  = COEF_B[4];
      first_in.neg  = in_neg;
      first_in.bad  = in_bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      st_ff[0] <= first_in;
   end

   // acc = b_i + acc * t, product truncated toward zero
   for (genvar j = 0; j < HORNER; j++) begin : g_horner
      localparam int CI = HORNER - 1 - j;
      pl_stage_type m_in;
      pl_stage_type a_in;
      logic [32:0]  mag;
      logic [33:0]  pm;

      always_comb begin
         mag        = st_ff[2*j].acc[33] ? 33'(-st_ff[2*j].acc) : 33'(st_ff[2*j].acc);
         m_in       = st_ff[2*j];
         m_in.msign = st_ff[2*j].acc[33];
         m_in.prod  = 64'(mag) * 64'(st_ff[2*j].t);
      end

      always_comb begin
         pm       = st_ff[2*j+1].prod[63:30];
         a_in     = st_ff[2*j+1];
         a_in.acc = st_ff[2*j+1].msign ? COEF_B[CI] - $signed(pm)
                                       : COEF_B[CI] + $signed(pm);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[2*j+1] <= 1'b0;
            vld_ff[2*j+2] <= 1'b0;
         end else begin
            vld_ff[2*j+1] <= vld_ff[2*j];
            vld_ff[2*j+2] <= vld_ff[2*j+1];
         end
         st_ff[2*j+1] <= m_in;
         st_ff[2*j+2] <= a_in;
      end
   end

   always_comb begin
      f1_in      = st_ff[2*HORNER];
      f1_in.pos  = st_ff[2*HORNER].acc[33] ? '0 : st_ff[2*HORNER].acc[32:0];
      f1_in.prod = 64'(st_ff[2*HORNER].dens) * 64'(st_ff[2*HORNER].t);

      f2_in      = st_ff[2*HORNER+1];
      f2_in.dt   = st_ff[2*HORNER+1].prod[59:30];
      f2_in.prod = 64'(st_ff[2*HORNER+1].prod[59:30]) * 64'(st_ff[2*HORNER+1].pos);

      // round Q30 to Q16
      f3_in     = st_ff[2*HORNER+2];
      f3_in.p16 = 17'((31'(st_ff[2*HORNER+2].prod[59:30]) + 31'd8192) >> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[2*HORNER+1] <= 1'b0;
         vld_ff[2*HORNER+2] <= 1'b0;
         vld_ff[2*HORNER+3] <= 1'b0;
      end else begin
         vld_ff[2*HORNER+1] <= vld_ff[2*HORNER];
         vld_ff[2*HORNER+2] <= vld_ff[2*HORNER+1];
         vld_ff[2*HORNER+3] <= vld_ff[2*HORNER+2];
      end
      st_ff[2*HORNER+1] <= f1_in;
      st_ff[2*HORNER+2] <= f2_in;
      st_ff[2*HORNER+3] <= f3_in;
   end

   always_comb begin
      p_sat = (st_ff[LAST].p16 > OUT_ONE) ? OUT_ONE : st_ff[LAST].p16;
      if (st_ff[LAST].bad) begin
         rsp_in.probability   = '0;
         rsp_in.bad_deviation = 1'b1;
      end else begin
         rsp_in.probability   = st_ff[LAST].neg ? p_sat : OUT_ONE - p_sat;
         rsp_in.bad_deviation = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[LAST];
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

### verif/ncdf_checker.sv
// ----------------------------------------------------------------------------
// ncdf_checker
// Watches the request and result channels of the normal CDF pipeline,
// computes the expected probability of every accepted transaction and
// compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdf_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ncdf_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  ncdf_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count
);
   import ncdf_pkg::*;

   localparam int QF = 30;
   localparam int ZF = 28;

   localparam longint CB [0:4] = '{
      64'sd342933307, -64'sd382857446, 64'sd1912847369,
      -64'sd1955558716, 64'sd1428371292
   };
   localparam bit [63:0] KT_Q32   = 64'd994894385;
   localparam bit [63:0] ISQ2PI   = 64'd428361012;
   localparam bit [63:0] LN2_Q30  = 64'd744261118;

   rsp_type expected_probs[$];

   assign pending_count = expected_probs.size();

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // signed accumulator times unsigned Q30 t, truncated toward zero
   function automatic longint scale_by_t(input longint a, input bit [63:0] t);
      bit [63:0] ua;
      if (a < 0) begin
         ua = -a;
         return -longint'((ua * t) >> QF);
      end
      return longint'(($unsigned(a) * t) >> QF);
   endfunction

   // exp(-w), w >= 0, both Q30: 2^-n * exp(-r) with a 12-step series
   function automatic bit [63:0] exp_negative(input bit [63:0] w);
      bit [63:0] n, r, term;
      longint    sum;
      n    = w / LN2_Q30;
      r    = w - n * LN2_Q30;
      term = 64'd1 << QF;
      sum  = longint'(term);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * r) >> QF) / k;
         if (k % 2 == 1) sum -= longint'(term);
         else            sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (n >= 63) return 0;
      return $unsigned(sum) >> n;
   endfunction

   function automatic rsp_type normal_cdf(input req_type rq);
      rsp_type   rs;
      longint    x, m, d, acc;
      bit [63:0] sd, ad, az, denom, t, w, dens, pt, p16;
      x  = longint'(rq.sample);
      m  = longint'(rq.mean);
      sd = 64'(rq.std_dev);
      d  = x - m;
      rs = '0;
      if (sd == 0) begin
         rs.bad_deviation = 1'b1;
         return rs;
      end
      ad = (d < 0) ? $unsigned(-d) : $unsigned(d);
      // |z| clamps at 8.0
      if (ad >= 8 * sd) az = 64'd8 << ZF;
      else              az = (ad << ZF) / sd;
      denom = (64'd1 << ZF) + ((az * KT_Q32) >> 32);
      t     = ((64'd1 << (ZF + QF)) + (denom >> 1)) / denom;
      w     = (az * az) >> (2 * ZF + 1 - QF);
      dens  = (exp_negative(w) * ISQ2PI) >> QF;
      acc = CB[4];
      for (int i = 3; i >= 0; i--)
         acc = CB[i] + scale_by_t(acc, t);
      if (acc < 0) acc = 0;
      pt  = (((dens * t) >> QF) * $unsigned(acc)) >> QF;
      p16 = (pt + (64'd1 << (QF - 17))) >> (QF - 16);
      if (p16 > 64'd65536) p16 = 64'd65536;
      // x == m counts as the upper half
      rs.probability = (d >= 0) ? 17'(64'd65536 - p16) : 17'(p16);
      return rs;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_probs.size() == 0) begin
               report_mismatch($sformatf("unexpected result prob=%0d bad=%0b",
                  rsp_data.probability, rsp_data.bad_deviation));
            end else begin
               exp_rsp = expected_probs.pop_front();
               checked_count++;
               if (rsp_data.probability !== exp_rsp.probability)
                  report_mismatch($sformatf("probability %0d, expected %0d",
                     rsp_data.probability, exp_rsp.probability));
               if (rsp_data.bad_deviation !== exp_rsp.bad_deviation)
                  report_mismatch($sformatf("bad_deviation %0b, expected %0b",
                     rsp_data.bad_deviation, exp_rsp.bad_deviation));
            end
         end
         if (start && !busy)
            expected_probs.insert(expected_probs.size(), normal_cdf(req_data));
      end
   end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the normal CDF pipeline: directed corner cases,
// then bursts of random transactions; checking is done by ncdf_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ncdf_pkg::*;

   localparam int NUM_RANDOM  = 1900;
   localparam int DRAIN_WAIT  = 300;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count, pending_count, checked_count;
   int cycle_count = 0;
   int sent_count  = 0;

   always #5 clock = ~clock;

   normal_cdf_polynomial u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   ncdf_checker u_chk (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Watchdog: a hung pipeline or a lost handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Present one transaction at the falling edge and hold it until taken.
   // start stays high if the next transaction follows back to back.
   task automatic send_cdf(input logic [31:0] x, input logic [31:0] m,
                           input logic [30:0] sd);
      @(negedge clock);
      start            <= 1'b1;
      req_data.sample  <= x;
      req_data.mean    <= m;
      req_data.std_dev <= sd;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic idle_cycles(input int n);
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Mostly realistic z in about +-9: sd spans tiny to wide, difference is
   // drawn relative to sd so the polynomial, the exponential and the clamp
   // are all exercised. The rest are degenerate cases or fully random bit patterns.
   task automatic send_random_cdf();
      logic [31:0] m, x;
      logic [30:0] sd;
      longint      dd;
      int          kind;
      kind = $urandom_range(0, 9);
      m    = $urandom;
      if (kind < 7) begin
         sd = (kind == 0) ? 31'($urandom_range(1, 255))
                          : 31'($urandom_range(1, 1 << 20));
         dd = longint'($urandom_range(0, 18 * sd)) - 9 * longint'(sd);
         x  = m + 32'(dd);
      end else if (kind == 7) begin
         // degenerate cases mixed into the traffic
         sd = ($urandom_range(0, 1) == 1) ? 31'd0 : 31'($urandom);
         x  = ($urandom_range(0, 1) == 1) ? m : 32'($urandom);
      end else begin
         sd = 31'($urandom);
         x  = $urandom;
      end
      send_cdf(x, m, sd);
   endtask

   initial begin
      int burst_len;
      bit paused;

      // synchronous reset
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed corners ---
      send_cdf(32'h0001_0000, 32'h0001_0000, 31'd0);           // zero deviation
      send_cdf(32'h8000_0000, 32'h7FFF_FFFF, 31'd0);           // zero dev, extremes
      send_cdf(32'h0000_0000, 32'h0000_0000, 31'h0001_0000);   // x == m
      send_cdf(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);   // largest d, largest sd
      send_cdf(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);   // most negative d
      send_cdf(32'h7FFF_FFFF, 32'h8000_0000, 31'd1);           // clamp, z > 0
      send_cdf(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);           // clamp, z < 0
      send_cdf(32'h0008_0000, 32'h0000_0000, 31'h0001_0000);   // exactly 8 sd
      send_cdf(32'hFFF8_0000, 32'h0000_0000, 31'h0001_0000);   // exactly -8 sd
      send_cdf(32'h0007_FFFF, 32'h0000_0000, 31'h0001_0000);   // just under 8
      send_cdf(32'h0000_0001, 32'h0000_0000, 31'h7FFF_FFFF);   // tiny z > 0, |z| truncates to 0
      send_cdf(32'hFFFF_FFFF, 32'h0000_0000, 31'h7FFF_FFFF);   // tiny z < 0
      send_cdf(32'h0001_0000, 32'h0000_0000, 31'h0001_0000);   // z = 1
      send_cdf(32'hFFFF_0000, 32'h0000_0000, 31'h0001_0000);   // z = -1
      send_cdf(32'h0002_0000, 32'h0000_0000, 31'h0001_0000);   // z = 2
      send_cdf(32'hFFFE_0000, 32'h0000_0000, 31'h0001_0000);   // z = -2
      send_cdf(32'h0000_0003, 32'h0000_0001, 31'd1);           // small-magnitude units
      send_cdf(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);   // largest positive, d = 0
      send_cdf(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA);   // alternating bits
      send_cdf(32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555);
      idle_cycles(3);

      // --- random bursts with random gaps ---
      paused = 0;
      while (sent_count < NUM_RANDOM + 20) begin
         burst_len = $urandom_range(1, 60);
         for (int i = 0; i < burst_len; i++)
            send_random_cdf();
         // drain once midway so the pipeline is seen empty and refilled
         if (!paused && sent_count > NUM_RANDOM / 2) begin
            paused = 1;
            idle_cycles(1);
            while (pending_count != 0) @(posedge clock);
         end
         // roughly a third of bursts run straight into the next one
         if ($urandom_range(0, 2) != 0)
            idle_cycles($urandom_range(1, 12));
      end
      idle_cycles(1);

      // wait for every expected result, then a margin for strays
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d transactions, %0d results checked, incl. zero deviation,",
               sent_count, checked_count);
      $display("clamped z, zero difference and full-range random fields");
      if (pending_count != 0)
         $display("%0d results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/ncdf_pkg.sv
rtl/core/ncdf_zdiv.sv
rtl/core/ncdf_recip.sv
rtl/core/ncdf_exp.sv
rtl/core/ncdf_poly.sv
rtl/core/normal_cdf_polynomial.sv
verif/ncdf_checker.sv
verif/tb.sv
